[hdl/cqs_pkg.sv]
// ----------------------------------------------------------------------------
// cqs_pkg: shared types and constants for the circular queue with search
// Operation and status codes, controller state and the result beat type.
// ----------------------------------------------------------------------------
package cqs_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;

	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_SRCH = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEQ,
		S_SRCH
	} state_t;

	typedef struct packed {
		logic                     valid;
		logic [1:0]               status;
		logic signed [WORD_W-1:0] data;
		logic                     found;
	} res_t;

endpackage

[hdl/cqs_ram.sv]
// ----------------------------------------------------------------------------
// cqs_ram: ring storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cqs_ram import cqs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic signed [WORD_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic signed [WORD_W-1:0] rdata
);

	logic signed [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/cqs_ctrl.sv]
// ----------------------------------------------------------------------------
// cqs_ctrl: queue controller
// Keeps head and tail pointers, drives the ring memory and walks the occupied
// slots one read per cycle for a search.
// ----------------------------------------------------------------------------
module cqs_ctrl import cqs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               op,
	input  logic signed [WORD_W-1:0] value,
	input  logic                     res_free,
	output res_t                     res,
	output logic                     ram_we,
	output logic [AW-1:0]            ram_waddr,
	output logic signed [WORD_W-1:0] ram_wdata,
	output logic [AW-1:0]            ram_raddr,
	input  logic signed [WORD_W-1:0] ram_rdata
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	state_t                   state_q, state_d;
	logic [AW-1:0]            head_q, head_d;
	logic [AW-1:0]            tail_q, tail_d;
	logic [AW-1:0]            f_q, f_d;
	logic signed [WORD_W-1:0] key_q, key_d;
	logic                     accept;
	logic                     empty;
	logic [AW-1:0]            tail_nx;
	logic [AW-1:0]            head_nx;

	assign empty   = (head_q == tail_q);
	assign tail_nx = next_slot(tail_q);
	assign head_nx = next_slot(head_q);
	assign in_stall = !((state_q == S_IDLE) && res_free);
	assign accept   = in_valid && !in_stall;

	assign ram_waddr = tail_nx;
	assign ram_wdata = value;
	assign ram_raddr = (state_q == S_IDLE) ? head_nx : next_slot(f_q);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		f_d        = f_q;
		key_d      = key_q;
		ram_we     = 1'b0;
		res.valid  = 1'b0;
		res.status = ST_OK;
		res.data   = '0;
		res.found  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op)
						OP_ENQ: begin
							res.valid = 1'b1;
							if (tail_nx == head_q) begin
								res.status = ST_FULL;
							end else begin
								ram_we = 1'b1;
								tail_d = tail_nx;
							end
						end
						OP_DEQ: begin
							if (empty) begin
								res.valid  = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								head_d  = head_nx;
								state_d = S_DEQ;
							end
						end
						OP_SRCH: begin
							if (empty) begin
								res.valid = 1'b1;
							end else begin
								f_d     = head_nx;
								key_d   = value;
								state_d = S_SRCH;
							end
						end
						default: begin
							res.valid = 1'b1;
						end
					endcase
				end
			end
			S_DEQ: begin
				res.valid = 1'b1;
				res.data  = ram_rdata;
				state_d   = S_IDLE;
			end
			S_SRCH: begin
				if (ram_rdata == key_q) begin
					res.valid = 1'b1;
					res.found = 1'b1;
					state_d   = S_IDLE;
				end else if (f_q == tail_q) begin
					res.valid = 1'b1;
					state_d   = S_IDLE;
				end else begin
					f_d = next_slot(f_q);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
		end
	end

	always_ff @(posedge clk) begin
		f_q   <= f_d;
		key_q <= key_d;
	end

endmodule

[hdl/circular_queue_with_search_core.sv]
// ----------------------------------------------------------------------------
// circular_queue_with_search_core: circular FIFO of 32-bit words with search
// Top level: controller, ring memory and the output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, op, value) takes one beat per operation:
//   enqueue, dequeue or search. Every input beat yields exactly one output
//   beat (out_valid/out_stall, status, data_out, found). The queue holds
//   DEPTH-1 words.
//   Enqueue, unused op codes, a full enqueue and a dequeue or search on an
//   empty queue answer from the idle state; a dequeue waits for one memory
//   read, and a search walks the queued words, one entry compared per cycle,
//   oldest first, stopping at the first match. Enqueue beats are taken one
//   per cycle while the output is not stalled; a dequeue or search is
//   finished before the next beat is taken.
//   One operation is in flight at a time; a new beat is taken once the
//   controller is idle and the output register is empty or being drained.
//   While out_stall holds a result in the output register, in_stall is high.
//   Reset empties the queue (head and tail pointers to zero); ring contents
//   are not cleared.
// ----------------------------------------------------------------------------
module circular_queue_with_search_core import cqs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               op,
	input  logic signed [WORD_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] data_out,
	output logic                     found
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	res_t                     res;
	logic                     res_free;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic signed [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]            ram_raddr;
	logic signed [WORD_W-1:0] ram_rdata;
	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic signed [WORD_W-1:0] data_q;
	logic                     found_q;

	assign res_free = !out_valid_q || !out_stall;

	cqs_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.value    (value),
		.res_free (res_free),
		.res      (res),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	cqs_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q <= res.status;
			data_q   <= res.data;
			found_q  <= res.found;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = data_q;
	assign found     = found_q;

endmodule

[sim/circular_queue_with_search_core_test.sv]
// ----------------------------------------------------------------------------
// circular_queue_with_search_core_test: self-checking bench for the queue core
// A short directed table covers the empty and full queue, the word extremes,
// hits and misses and the unused op code. Random phases follow: fill-heavy,
// drain-heavy and mixed traffic with random idling on both channels. Every
// result beat is checked against the table or a software copy of the queue.
// ----------------------------------------------------------------------------
module circular_queue_with_search_core_test;
	import cqs_pkg::*;

	localparam int QDEPTH = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1200;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic               found;
	} outcome_t;

	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] word;
		bit                 known;
		outcome_t           want;
	} row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               op = OP_ENQ;
	logic signed [WORD_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               status;
	logic signed [WORD_W-1:0] data_out;
	logic                     found;

	// shadow queue
	logic [31:0] ring [QDEPTH];
	int          head_ptr = 0;
	int          tail_ptr = 0;

	outcome_t pending [$];
	row_t     table_rows [$];
	int       errors = 0;
	bit       tx_idle_on = 1'b1;
	bit       rx_idle_on = 1'b1;

	circular_queue_with_search_core #(.DEPTH(QDEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.data_out (data_out),
		.found    (found)
	);

	always #10 clk = ~clk;

	function automatic int next_ptr(int i);
		return (i + 1 >= QDEPTH) ? 0 : i + 1;
	endfunction

	function automatic int queue_count();
		return (tail_ptr - head_ptr + QDEPTH) % QDEPTH;
	endfunction

	function automatic outcome_t queue_apply(logic [1:0] kind, logic [31:0] word);
		outcome_t r;
		int       p;
		r = '{status: ST_OK, data: '0, found: 1'b0};
		case (kind)
			OP_ENQ: begin
				if (next_ptr(tail_ptr) == head_ptr) begin
					r.status = ST_FULL;
				end else begin
					tail_ptr = next_ptr(tail_ptr);
					ring[tail_ptr] = word;
				end
			end
			OP_DEQ: begin
				if (head_ptr == tail_ptr) begin
					r.status = ST_EMPTY;
				end else begin
					head_ptr = next_ptr(head_ptr);
					r.data = ring[head_ptr];
				end
			end
			OP_SRCH: begin
				p = head_ptr;
				while (p != tail_ptr && !r.found) begin
					p = next_ptr(p);
					if (ring[p] == word)
						r.found = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] random_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
		else if (r < 40)
			return 32'($signed($urandom_range(0, 8)) - 4);
		else
			return $urandom;
	endfunction

	// key that hits an occupied slot most of the time
	function automatic logic [31:0] random_key();
		int n;
		n = queue_count();
		if (n != 0 && $urandom_range(0, 99) < 60)
			return ring[(head_ptr + 1 + $urandom_range(0, n - 1)) % QDEPTH];
		return random_word();
	endfunction

	function automatic void add_row(logic [1:0] kind, logic [31:0] word, bit known,
			logic [1:0] st, logic [31:0] dat, logic fnd);
		row_t r;
		r.kind = kind;
		r.word = word;
		r.known = known;
		r.want = '{status: st, data: dat, found: fnd};
		table_rows.push_back(r);
	endfunction

	task automatic flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic send_beat(logic [1:0] kind, logic [31:0] word, bit known, outcome_t want);
		int       gap;
		outcome_t calc;
		gap = tx_idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		value <= word;
		do @(posedge clk); while (in_stall);
		calc = queue_apply(kind, word);
		pending.push_back(known ? want : calc);
	endtask

	// result side
	int stall_left = 0;
	always @(posedge clk) begin
		outcome_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending.size() == 0) begin
					flag_error($sformatf("unexpected beat status=%0d data=%0d found=%0b",
						status, data_out, found));
				end else begin
					w = pending.pop_front();
					if (status !== w.status || data_out !== w.data || found !== w.found)
						flag_error($sformatf(
							"exp status=%0d data=%0d found=%0b, got status=%0d data=%0d found=%0b",
							w.status, w.data, w.found, status, data_out, found));
				end
				stall_left = rx_idle_on ? $urandom_range(0, 16) : 0;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	initial begin
		#10_000_000;
		$display("circular_queue_with_search_core_test: errors");
		$finish;
	end

	initial begin
		int       sent;
		int       mode;
		int       plen;
		int       r;
		bit       paused;
		logic [1:0] kind;
		outcome_t none;

		none = '{status: ST_OK, data: '0, found: 1'b0};
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		add_row(OP_DEQ, 32'd0, 1, ST_EMPTY, 32'd0, 1'b0);
		add_row(OP_SRCH, 32'd0, 1, ST_OK, 32'd0, 1'b0);
		add_row(OP_NONE, 32'hFFFF_FFFF, 1, ST_OK, 32'd0, 1'b0);
		add_row(OP_ENQ, 32'h7FFF_FFFF, 1, ST_OK, 32'd0, 1'b0);
		add_row(OP_ENQ, 32'h8000_0000, 1, ST_OK, 32'd0, 1'b0);
		add_row(OP_SRCH, 32'h8000_0000, 1, ST_OK, 32'd0, 1'b1);
		add_row(OP_SRCH, 32'd0, 1, ST_OK, 32'd0, 1'b0);
		add_row(OP_DEQ, 32'd0, 1, ST_OK, 32'h7FFF_FFFF, 1'b0);
		add_row(OP_DEQ, 32'd0, 1, ST_OK, 32'h8000_0000, 1'b0);
		add_row(OP_DEQ, 32'd0, 1, ST_EMPTY, 32'd0, 1'b0);
		for (int i = 0; i < QDEPTH - 1; i++)
			add_row(OP_ENQ, 32'h0101_0101 * (i + 1), 1, ST_OK, 32'd0, 1'b0);
		add_row(OP_ENQ, 32'hDEAD_BEEF, 1, ST_FULL, 32'd0, 1'b0);
		add_row(OP_SRCH, 32'h0F0F_0F0F, 0, ST_OK, 32'd0, 1'b0);
		add_row(OP_SRCH, 32'hDEAD_BEEF, 0, ST_OK, 32'd0, 1'b0);

		foreach (table_rows[i])
			send_beat(table_rows[i].kind, table_rows[i].word, table_rows[i].known,
				table_rows[i].want);

		sent = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 2);
			plen = $urandom_range(20, 60);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < plen && sent < RANDOM_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				case (mode)
					0: kind = (r < 70) ? OP_ENQ : (r < 80) ? OP_DEQ : (r < 98) ? OP_SRCH : OP_NONE;
					1: kind = (r < 15) ? OP_ENQ : (r < 80) ? OP_DEQ : (r < 98) ? OP_SRCH : OP_NONE;
					default: kind = (r < 35) ? OP_ENQ : (r < 65) ? OP_DEQ : (r < 98) ? OP_SRCH
						: OP_NONE;
				endcase
				send_beat(kind, (kind == OP_SRCH) ? random_key() : random_word(), 0, none);
				sent++;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				while (pending.size() != 0) @(posedge clk);
			end
		end

		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (QDEPTH + 4) @(posedge clk);
		if (pending.size() != 0)
			flag_error("results still outstanding");
		if (errors == 0)
			$display("circular_queue_with_search_core_test: clean");
		else
			$display("circular_queue_with_search_core_test: errors");
		$finish;
	end

endmodule

[filelist.f]
hdl/cqs_pkg.sv
hdl/cqs_ram.sv
hdl/cqs_ctrl.sv
hdl/circular_queue_with_search_core.sv
sim/circular_queue_with_search_core_test.sv
